/* rtl/ihex_enc_pkg.sv */
package ihex_enc_pkg;

  localparam int LINE_BYTES = 16;
  localparam int POS_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APPEND_END = 2'd2;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // type 04 record: byte count 02 plus record type 04
  localparam logic [7:0] ELA_FIXED_SUM = 8'h06;

  // position of each character within the longest burst of one request
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] IDX_ELA = 6'd0;
  localparam logic [IDX_W-1:0] IDX_ELA_HI = 6'd9;
  localparam logic [IDX_W-1:0] IDX_ELA_CKS = 6'd13;
  localparam logic [IDX_W-1:0] IDX_ELA_LF = 6'd15;
  localparam logic [IDX_W-1:0] IDX_HDR = 6'd16;
  localparam logic [IDX_W-1:0] IDX_HDR_LEN = 6'd17;
  localparam logic [IDX_W-1:0] IDX_HDR_LO = 6'd19;
  localparam logic [IDX_W-1:0] IDX_HDR_TYPE = 6'd23;
  localparam logic [IDX_W-1:0] IDX_DATA = 6'd25;
  localparam logic [IDX_W-1:0] IDX_DATA_LAST = 6'd26;
  localparam logic [IDX_W-1:0] IDX_CLOSE = 6'd27;
  localparam logic [IDX_W-1:0] IDX_CLOSE_LF = 6'd29;
  localparam logic [IDX_W-1:0] IDX_END = 6'd30;
  localparam logic [IDX_W-1:0] IDX_END_LF = 6'd41;

  // ":02000004"
  localparam logic [7:0] ELA_TEXT [9] = '{
    8'h3A, 8'h30, 8'h32, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h34
  };

  // ":00000001FF" LF
  localparam logic [7:0] END_TEXT [12] = '{
    8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
    8'h31, 8'h46, 8'h46, 8'h0A
  };

  typedef struct packed {
    logic                 ela;
    logic [15:0]          ela_hi;
    logic [7:0]           ela_cks;
    logic                 hdr;
    logic [7:0]           len;
    logic [15:0]          lo;
    logic [7:0]           data;
    logic                 close;
    logic [7:0]           cks;
    logic                 endrec;
    logic [IDX_W-1:0]     start;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'h0, n};
    else           c = 8'h37 + {4'h0, n};
    return c;
  endfunction

endpackage

/* rtl/ihex_enc_front.sv */
module ihex_enc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [7:0]                        in_data_byte,
  output logic                              in_stall,
  input  logic [31:0]                       load_addr,
  input  logic [31:0]                       image_size,
  input  logic                              append_end,
  input  logic                              q_full,
  output logic                              push,
  output ihex_enc_pkg::cmd_t                cmd
);

  logic [31:0]                     offset_r, offset_nxt;
  logic [31:0]                     start_r, start_nxt;
  logic [ihex_enc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]                     upper_r, upper_nxt;
  logic [7:0]                      sum_r, sum_nxt;

  logic [31:0] size;
  logic [31:0] addr;
  logic [31:0] remaining;
  logic        last_img;
  logic        at_start;
  logic        rec_end;
  logic [7:0]  len;
  logic [7:0]  ela_sum;
  logic [7:0]  hdr_sum;
  logic [7:0]  cur_sum;
  logic        ela;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  always_comb begin
    size = (image_size == 32'd0) ? 32'd1 : image_size;
    last_img = offset_r >= (size - 32'd1);
    at_start = (pos_r == '0);
    rec_end = (pos_r == ihex_enc_pkg::POS_W'(ihex_enc_pkg::LINE_BYTES - 1)) || last_img;
    addr = load_addr + start_r;
    remaining = (size > start_r) ? (size - start_r) : 32'd1;
    len = (remaining < 32'(ihex_enc_pkg::LINE_BYTES)) ? remaining[7:0]
                                                       : 8'(ihex_enc_pkg::LINE_BYTES);
    ela = at_start && (addr[31:16] != upper_r);
    ela_sum = ihex_enc_pkg::ELA_FIXED_SUM + addr[31:24] + addr[23:16];
    hdr_sum = len + addr[15:8] + addr[7:0];
    cur_sum = (at_start ? hdr_sum : sum_r) + in_data_byte;

    cmd.ela = ela;
    cmd.ela_hi = addr[31:16];
    cmd.ela_cks = 8'h00 - ela_sum;
    cmd.hdr = at_start;
    cmd.len = len;
    cmd.lo = addr[15:0];
    cmd.data = in_data_byte;
    cmd.close = rec_end;
    cmd.cks = 8'h00 - cur_sum;
    cmd.endrec = last_img && append_end;
    if (ela)           cmd.start = ihex_enc_pkg::IDX_ELA;
    else if (at_start) cmd.start = ihex_enc_pkg::IDX_HDR;
    else               cmd.start = ihex_enc_pkg::IDX_DATA;
  end

  always_comb begin
    offset_nxt = offset_r;
    start_nxt = start_r;
    pos_nxt = pos_r;
    upper_nxt = upper_r;
    sum_nxt = sum_r;
    if (push) begin
      if (last_img) begin
        // image done: restart offsets and upper address
        offset_nxt = '0;
        start_nxt = '0;
        pos_nxt = '0;
        upper_nxt = '0;
        sum_nxt = '0;
      end else begin
        offset_nxt = offset_r + 32'd1;
        sum_nxt = cur_sum;
        if (ela) upper_nxt = addr[31:16];
        if (rec_end) begin
          pos_nxt = '0;
          start_nxt = offset_r + 32'd1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      start_r <= '0;
      pos_r <= '0;
      upper_r <= '0;
      sum_r <= '0;
    end else begin
      offset_r <= offset_nxt;
      start_r <= start_nxt;
      pos_r <= pos_nxt;
      upper_r <= upper_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

/* rtl/ihex_enc_queue.sv */
module ihex_enc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ihex_enc_pkg::cmd_t wr_cmd,
  output logic               full,
  input  logic               rd_en,
  output logic               head_valid,
  output ihex_enc_pkg::cmd_t head
);

  ihex_enc_pkg::cmd_t                 mem_r [ihex_enc_pkg::QUEUE_DEPTH];
  logic [ihex_enc_pkg::QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [ihex_enc_pkg::QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [ihex_enc_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                               do_wr;
  logic                               do_rd;

  localparam logic [ihex_enc_pkg::QPTR_W-1:0] PTR_LAST =
    ihex_enc_pkg::QPTR_W'(ihex_enc_pkg::QUEUE_DEPTH - 1);

  assign full = (cnt_r == ihex_enc_pkg::QCNT_W'(ihex_enc_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head = mem_r[rptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && head_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt = cnt_r;
    if (do_wr) wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    if (do_rd) rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    if (do_wr && !do_rd)      cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_cmd;
  end

endmodule

/* rtl/ihex_enc_back.sv */
module ihex_enc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  ihex_enc_pkg::cmd_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_ascii_char,
  output logic               out_run_end
);

  logic                           out_valid_r, out_valid_nxt;
  logic [7:0]                     char_r;
  logic                           run_end_r;
  logic [ihex_enc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                           fresh_r, fresh_nxt;

  logic                           load;
  logic [ihex_enc_pkg::IDX_W-1:0] cur;
  logic [ihex_enc_pkg::IDX_W-1:0] off;
  logic                           last;
  logic [7:0]                     ch;

  assign out_valid = out_valid_r;
  assign out_ascii_char = char_r;
  assign out_run_end = run_end_r;

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign cur = fresh_r ? head.start : idx_r;
  assign pop = load && last;

  always_comb begin
    last = ((cur == ihex_enc_pkg::IDX_DATA_LAST) && !head.close && !head.endrec)
        || ((cur == ihex_enc_pkg::IDX_CLOSE_LF) && !head.endrec)
        || (cur == ihex_enc_pkg::IDX_END_LF);

    if (cur == ihex_enc_pkg::IDX_ELA_LF)
      idx_nxt = ihex_enc_pkg::IDX_HDR;
    else if (cur == ihex_enc_pkg::IDX_DATA_LAST)
      idx_nxt = head.close ? ihex_enc_pkg::IDX_CLOSE : ihex_enc_pkg::IDX_END;
    else if (cur == ihex_enc_pkg::IDX_CLOSE_LF)
      idx_nxt = ihex_enc_pkg::IDX_END;
    else
      idx_nxt = cur + 1'b1;
  end

  // character at the current position of the burst
  always_comb begin
    off = '0;
    if (cur < ihex_enc_pkg::IDX_ELA_HI) begin
      ch = ihex_enc_pkg::ELA_TEXT[cur[3:0]];
    end else if (cur < ihex_enc_pkg::IDX_ELA_CKS) begin
      off = cur - ihex_enc_pkg::IDX_ELA_HI;
      ch = ihex_enc_pkg::hex_char(4'(head.ela_hi >> {~off[1:0], 2'b00}));
    end else if (cur < ihex_enc_pkg::IDX_ELA_LF) begin
      off = cur - ihex_enc_pkg::IDX_ELA_CKS;
      ch = ihex_enc_pkg::hex_char(4'(head.ela_cks >> {~off[0], 2'b00}));
    end else if (cur == ihex_enc_pkg::IDX_ELA_LF) begin
      ch = ihex_enc_pkg::CHAR_LF;
    end else if (cur == ihex_enc_pkg::IDX_HDR) begin
      ch = ihex_enc_pkg::CHAR_COLON;
    end else if (cur < ihex_enc_pkg::IDX_HDR_LO) begin
      off = cur - ihex_enc_pkg::IDX_HDR_LEN;
      ch = ihex_enc_pkg::hex_char(4'(head.len >> {~off[0], 2'b00}));
    end else if (cur < ihex_enc_pkg::IDX_HDR_TYPE) begin
      off = cur - ihex_enc_pkg::IDX_HDR_LO;
      ch = ihex_enc_pkg::hex_char(4'(head.lo >> {~off[1:0], 2'b00}));
    end else if (cur < ihex_enc_pkg::IDX_DATA) begin
      ch = ihex_enc_pkg::CHAR_ZERO;
    end else if (cur < ihex_enc_pkg::IDX_CLOSE) begin
      off = cur - ihex_enc_pkg::IDX_DATA;
      ch = ihex_enc_pkg::hex_char(4'(head.data >> {~off[0], 2'b00}));
    end else if (cur < ihex_enc_pkg::IDX_CLOSE_LF) begin
      off = cur - ihex_enc_pkg::IDX_CLOSE;
      ch = ihex_enc_pkg::hex_char(4'(head.cks >> {~off[0], 2'b00}));
    end else if (cur == ihex_enc_pkg::IDX_CLOSE_LF) begin
      ch = ihex_enc_pkg::CHAR_LF;
    end else begin
      off = cur - ihex_enc_pkg::IDX_END;
      ch = ihex_enc_pkg::END_TEXT[off[3:0]];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    fresh_nxt = fresh_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      fresh_nxt = last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fresh_r <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= ch;
      run_end_r <= last;
      idx_r <= idx_nxt;
    end
  end

endmodule

/* rtl/intel_hex_record_encoder.sv */
// A two-entry request queue decouples input and output. A byte is written into it,
// then its first character goes through the output register. One character per
// cycle leaves it while out_stall is low; a byte yields 2 to 42 characters (two hex
// digits plus record overhead share, about 2.75 on average with 16-byte records).
// Reset (rst_n low, synchronous) clears the queue, the output register, the image
// offset and upper address, and loads base 0, size 1, end record off.
module intel_hex_record_encoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_data_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            out_ascii_char,
  output logic                                  out_run_end,
  input  logic                                  cfg_we,
  input  logic [ihex_enc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ihex_enc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [31:0]        load_addr_r;
  logic [31:0]        image_size_r;
  logic               append_end_r;

  logic               q_full;
  logic               push;
  logic               pop;
  logic               head_valid;
  ihex_enc_pkg::cmd_t cmd;
  ihex_enc_pkg::cmd_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= 32'd0;
      image_size_r <= 32'd1;
      append_end_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ihex_enc_pkg::CFG_BASE_ADDRESS: load_addr_r <= cfg_wdata[31:0];
        ihex_enc_pkg::CFG_IMAGE_SIZE:   image_size_r <= cfg_wdata[31:0];
        ihex_enc_pkg::CFG_APPEND_END:   append_end_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ihex_enc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .load_addr    (load_addr_r),
    .image_size   (image_size_r),
    .append_end   (append_end_r),
    .q_full       (q_full),
    .push         (push),
    .cmd          (cmd)
  );

  ihex_enc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (push),
    .wr_cmd     (cmd),
    .full       (q_full),
    .rd_en      (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ihex_enc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_run_end    (out_run_end)
  );

endmodule

/* rtl/ihex_enc_checker.sv */
module ihex_enc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_ascii_char,
  input logic       out_run_end
);

  // a stalled character stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output dropped while stalled");

  // hold the stalled character and its flag
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ascii_char) && $stable(out_run_end))
    else $error("output changed while stalled");

  // a record start never closes a burst
  a_colon_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ascii_char == ihex_enc_pkg::CHAR_COLON |-> !out_run_end)
    else $error("burst ends on a colon");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind intel_hex_record_encoder ihex_enc_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ascii_char (out_ascii_char),
  .out_run_end    (out_run_end)
);
